[hdl/ttpd_pkg.sv]
// Tiled texture pixel decoder: shared types, register codes and channel helpers.
// Used by every file of the block; depends on nothing.

package ttpd_pkg;

   // Fixed field widths
   localparam int unsigned IDX_W  = 20;
   localparam int unsigned BYTE_W = 8;

   // Texel formats, as written to the pixel_format register
   typedef enum logic [2:0] {
      FMT_RGBA8888 = 3'd0,
      FMT_RGB888   = 3'd1,
      FMT_RGBA5551 = 3'd2,
      FMT_RGB565   = 3'd3,
      FMT_LA88     = 3'd4,
      FMT_A8       = 3'd5,
      FMT_LA44     = 3'd6,
      FMT_A4       = 3'd7
   } fmt_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT = 2'd0,
      CSR_WIDTH_TILES  = 2'd1,
      CSR_HEIGHT_TILES = 2'd2
   } csr_index_type;

   // One assembled texel: up to four bytes, newest byte in the low byte
   typedef struct packed {
      logic [31:0] data;
      logic        last_image;
   } texel_type;

   // One result pixel
   typedef struct packed {
      logic [IDX_W-1:0] pixel_index;
      logic [7:0]       blue;
      logic [7:0]       green;
      logic [7:0]       red;
      logic [7:0]       alpha;
      logic             run_end;
      logic             image_end;
   } pixel_type;

   // Pixels produced by one texel; second is used only in A4
   typedef struct packed {
      pixel_type first;
      pixel_type second;
      logic      two;
   } pair_type;

   // Byte phase at which a texel of this format is complete
   function automatic logic [1:0] last_phase(input fmt_type fmt);
      logic [1:0] lp;
      unique case (fmt)
         FMT_RGBA8888: lp = 2'd3;
         FMT_RGB888:   lp = 2'd2;
         FMT_RGBA5551,
         FMT_RGB565,
         FMT_LA88:     lp = 2'd1;
         FMT_A8,
         FMT_LA44,
         FMT_A4:       lp = 2'd0;
      endcase
      return lp;
   endfunction

   // 5-bit channel to 8 bits by bit replication
   function automatic logic [7:0] grow5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   // 6-bit channel to 8 bits by bit replication
   function automatic logic [7:0] grow6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // 4-bit value times 0x11
   function automatic logic [7:0] grow4(input logic [3:0] v);
      return {v, v};
   endfunction

endpackage

[hdl/ttpd_if.sv]
// Tiled texture pixel decoder: valid/ready channel interfaces (byte input,
// pixel result, register write). Depends on ttpd_pkg.

interface ttpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] raw_byte;

   modport source (output valid, output raw_byte, input ready);
   modport sink   (input valid, input raw_byte, output ready);
endinterface

interface ttpd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ttpd_pkg::IDX_W-1:0]  pixel_index;
   logic [7:0]                  blue;
   logic [7:0]                  green;
   logic [7:0]                  red;
   logic [7:0]                  alpha;
   logic                        run_end;
   logic                        image_end;

   modport source (output valid, output pixel_index, output blue, output green,
                   output red, output alpha, output run_end, output image_end,
                   input ready);
   modport sink   (input valid, input pixel_index, input blue, input green,
                   input red, input alpha, input run_end, input image_end,
                   output ready);
endinterface

interface ttpd_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/ttpd_gather.sv]
// Tiled texture pixel decoder: byte gathering and tile walk. Holds partial
// texels, tracks the Morton position and registers each finished texel.
// Depends on ttpd_pkg and ttpd_if.

module ttpd_gather #(
   parameter int unsigned COL_W = 7,
   parameter int unsigned ROW_W = 7,
   parameter int unsigned WT_W  = 8,
   parameter int unsigned HT_W  = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  ttpd_pkg::fmt_type         fmt,
   input  logic [WT_W-1:0]           wt,
   input  logic [HT_W-1:0]           ht,
   ttpd_req_if.sink                  req,
   output logic                      tex_valid,
   input  logic                      tex_ready,
   output ttpd_pkg::texel_type       texel,
   output logic [ROW_W+2:0]          row,
   output logic [COL_W+2:0]          col
);

   logic [1:0]          phase_ff, phase_in;
   logic [23:0]         held_ff, held_in;
   logic [5:0]          texel_ff, texel_in;
   logic [COL_W-1:0]    tile_col_ff, tile_col_in;
   logic [ROW_W-1:0]    tile_row_ff, tile_row_in;
   logic                tex_valid_ff, tex_valid_in;
   ttpd_pkg::texel_type tex_ff;
   logic [ROW_W+2:0]    row_ff;
   logic [COL_W+2:0]    col_ff;

   logic                completes;
   logic                accept;
   logic                fire;
   logic [6:0]          t_sum;
   logic                last_texel;
   logic [WT_W-1:0]     col_plus;
   logic [HT_W-1:0]     row_plus;
   logic                col_wrap;
   logic                row_wrap;
   logic [2:0]          x_pos;
   logic [2:0]          y_pos;

   // Morton position inside the tile
   assign x_pos = {texel_ff[4], texel_ff[2], texel_ff[0]};
   assign y_pos = {texel_ff[5], texel_ff[3], texel_ff[1]};

   // Handshake: a byte that finishes a texel needs room in the texel register
   assign completes = (phase_ff >= ttpd_pkg::last_phase(fmt));
   assign req.ready = !completes || !tex_valid_ff || tex_ready;
   assign accept    = req.valid && req.ready;
   assign fire      = accept && completes;

   // Tile walk arithmetic
   always_comb begin
      t_sum      = {1'b0, texel_ff} + ((fmt == ttpd_pkg::FMT_A4) ? 7'd2 : 7'd1);
      last_texel = t_sum[6];
      col_plus   = WT_W'(tile_col_ff) + WT_W'(1);
      row_plus   = HT_W'(tile_row_ff) + HT_W'(1);
      col_wrap   = (col_plus >= wt);
      row_wrap   = (row_plus >= ht);
   end

   // Next state
   always_comb begin
      phase_in     = phase_ff;
      held_in      = held_ff;
      texel_in     = texel_ff;
      tile_col_in  = tile_col_ff;
      tile_row_in  = tile_row_ff;
      tex_valid_in = tex_valid_ff;
      if (tex_valid_ff && tex_ready) begin
         tex_valid_in = 1'b0;
      end
      if (accept && !completes) begin
         phase_in = phase_ff + 2'd1;
         held_in  = {held_ff[15:0], req.raw_byte};
      end
      if (fire) begin
         phase_in     = '0;
         held_in      = '0;
         tex_valid_in = 1'b1;
         if (last_texel) begin
            texel_in = '0;
            if (col_wrap) begin
               tile_col_in = '0;
               tile_row_in = row_wrap ? '0 : row_plus[ROW_W-1:0];
            end else begin
               tile_col_in = col_plus[COL_W-1:0];
            end
         end else begin
            texel_in = t_sum[5:0];
         end
      end
      if (clear) begin
         phase_in     = '0;
         held_in      = '0;
         texel_in     = '0;
         tile_col_in  = '0;
         tile_row_in  = '0;
         tex_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         held_ff      <= '0;
         texel_ff     <= '0;
         tile_col_ff  <= '0;
         tile_row_ff  <= '0;
         tex_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         texel_ff     <= texel_in;
         tile_col_ff  <= tile_col_in;
         tile_row_ff  <= tile_row_in;
         tex_valid_ff <= tex_valid_in;
      end
   end

   // Finished texel and its pixel position
   always_ff @(posedge clock) begin
      if (fire) begin
         tex_ff.data       <= {held_ff, req.raw_byte};
         tex_ff.last_image <= last_texel && col_wrap && row_wrap;
         row_ff            <= {tile_row_ff, y_pos};
         col_ff            <= {tile_col_ff, x_pos};
      end
   end

   assign tex_valid = tex_valid_ff;
   assign texel     = tex_ff;
   assign row       = row_ff;
   assign col       = col_ff;

endmodule

[hdl/ttpd_expand.sv]
// Tiled texture pixel decoder: texel expansion to 8-bit BGRA and the
// destination index multiply. Pure logic; depends on ttpd_pkg.

module ttpd_expand #(
   parameter int unsigned ROW_BITS = 10,
   parameter int unsigned COL_BITS = 10,
   parameter int unsigned WT_BITS  = 8
) (
   input  ttpd_pkg::fmt_type    fmt,
   input  ttpd_pkg::texel_type  texel,
   input  logic [ROW_BITS-1:0]  row,
   input  logic [COL_BITS-1:0]  col,
   input  logic [WT_BITS-1:0]   wt,
   output ttpd_pkg::pair_type   pair
);

   localparam int unsigned PROD_W = ROW_BITS + WT_BITS;
   localparam int unsigned SUM_W  = (PROD_W + 3 > ttpd_pkg::IDX_W) ?
                                    PROD_W + 3 : ttpd_pkg::IDX_W;

   logic [PROD_W-1:0]          prod;
   logic [SUM_W-1:0]           base;
   logic [ttpd_pkg::IDX_W-1:0] idx;
   logic [7:0]                 cur;
   logic [7:0]                 h0;
   logic [7:0]                 h1;
   logic [7:0]                 h2;
   logic [15:0]                p16;

   // Index: row * (8 * width) + column
   always_comb begin
      prod = PROD_W'(row) * PROD_W'(wt);
      base = (SUM_W'(prod) << 3) + SUM_W'(col);
      idx  = base[ttpd_pkg::IDX_W-1:0];
   end

   assign cur = texel.data[7:0];
   assign h0  = texel.data[15:8];
   assign h1  = texel.data[23:16];
   assign h2  = texel.data[31:24];
   // little-endian 16-bit word: newest byte is the high byte
   assign p16 = {cur, h0};

   // Channel expansion per format
   always_comb begin
      pair.first.pixel_index  = idx;
      pair.first.run_end      = 1'b1;
      pair.first.image_end    = texel.last_image;
      pair.first.blue         = 8'hFF;
      pair.first.green        = 8'hFF;
      pair.first.red          = 8'hFF;
      pair.first.alpha        = 8'hFF;
      pair.second.pixel_index = {idx[ttpd_pkg::IDX_W-1:1], 1'b1};
      pair.second.blue        = 8'hFF;
      pair.second.green       = 8'hFF;
      pair.second.red         = 8'hFF;
      pair.second.alpha       = ttpd_pkg::grow4(cur[7:4]);
      pair.second.run_end     = 1'b1;
      pair.second.image_end   = texel.last_image;
      pair.two                = 1'b0;
      unique case (fmt)
         ttpd_pkg::FMT_RGBA8888: begin
            pair.first.blue  = cur;
            pair.first.green = h0;
            pair.first.red   = h1;
            pair.first.alpha = h2;
         end
         ttpd_pkg::FMT_RGB888: begin
            pair.first.blue  = cur;
            pair.first.green = h0;
            pair.first.red   = h1;
         end
         ttpd_pkg::FMT_RGBA5551: begin
            pair.first.blue  = ttpd_pkg::grow5(p16[15:11]);
            pair.first.green = ttpd_pkg::grow5(p16[10:6]);
            pair.first.red   = ttpd_pkg::grow5(p16[5:1]);
            pair.first.alpha = p16[0] ? 8'hFF : 8'h00;
         end
         ttpd_pkg::FMT_RGB565: begin
            pair.first.blue  = ttpd_pkg::grow5(p16[15:11]);
            pair.first.green = ttpd_pkg::grow6(p16[10:5]);
            pair.first.red   = ttpd_pkg::grow5(p16[4:0]);
         end
         ttpd_pkg::FMT_LA88: begin
            pair.first.blue  = h0;
            pair.first.green = h0;
            pair.first.red   = h0;
            pair.first.alpha = cur;
         end
         ttpd_pkg::FMT_A8: begin
            pair.first.alpha = cur;
         end
         ttpd_pkg::FMT_LA44: begin
            pair.first.blue  = ttpd_pkg::grow4(cur[3:0]);
            pair.first.green = ttpd_pkg::grow4(cur[3:0]);
            pair.first.red   = ttpd_pkg::grow4(cur[3:0]);
            pair.first.alpha = ttpd_pkg::grow4(cur[7:4]);
         end
         ttpd_pkg::FMT_A4: begin
            // low nibble to the even column, high nibble to its neighbor
            pair.first.alpha     = ttpd_pkg::grow4(cur[3:0]);
            pair.first.run_end   = 1'b0;
            pair.first.image_end = 1'b0;
            pair.two             = 1'b1;
         end
      endcase
   end

endmodule

[hdl/ttpd_emit.sv]
// Tiled texture pixel decoder: result register. Holds the pixels of one texel
// and hands them out one item at a time. Depends on ttpd_pkg and ttpd_if.

module ttpd_emit (
   input  logic                clock,
   input  logic                reset,
   input  ttpd_pkg::pair_type  pair,
   input  logic                pair_valid,
   output logic                pair_ready,
   ttpd_rsp_if.source          rsp
);

   ttpd_pkg::pair_type  pair_ff;
   logic                valid_ff, valid_in;
   logic                sel_ff, sel_in;
   ttpd_pkg::pixel_type cur_pix;
   logic                last_pix;
   logic                moved;
   logic                done;
   logic                load;

   assign cur_pix    = sel_ff ? pair_ff.second : pair_ff.first;
   assign last_pix   = !pair_ff.two || sel_ff;
   assign moved      = valid_ff && rsp.ready;
   assign done       = moved && last_pix;
   assign pair_ready = !valid_ff || done;
   assign load       = pair_valid && pair_ready;

   // Slot control
   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = 1'b0;
      end else if (done) begin
         valid_in = 1'b0;
         sel_in   = 1'b0;
      end else if (moved) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pair_ff <= pair;
      end
   end

   // Result channel
   assign rsp.valid       = valid_ff;
   assign rsp.pixel_index = cur_pix.pixel_index;
   assign rsp.blue        = cur_pix.blue;
   assign rsp.green       = cur_pix.green;
   assign rsp.red         = cur_pix.red;
   assign rsp.alpha       = cur_pix.alpha;
   assign rsp.run_end     = cur_pix.run_end;
   assign rsp.image_end   = cur_pix.image_end;

endmodule

[hdl/tiled_texture_pixel_decoder_unit.sv]
// Tiled texture pixel decoder, top level: configuration registers, byte
// gathering, expansion and result register. Depends on ttpd_pkg, ttpd_if,
// ttpd_gather, ttpd_expand and ttpd_emit.

// Takes one texture byte per cycle while the texel register has room and
// gives one 8-bit BGRA pixel per completed texel (two for A4), with its
// destination index (row * 8 * width_tiles + column, low 20 bits). Texels
// arrive in 8x8 tiles in Morton order, tiles row by row; after the last pixel
// of the image the walk restarts at the first tile. Multi-byte formats take 2
// to 4 bytes per pixel; A4 gives two pixels per byte, which the result register
// hands out one at a time before it takes the next texel. A byte that finishes
// a texel is registered in the texel register, then passes through the
// expansion and the index multiplier (one row-by-width multiply) into the
// result register. Any write to a known register clears the walk and drops a
// partial texel; write only while the block is idle. The width and height
// registers clamp to 1..MAX_TILES_WIDE and 1..MAX_TILES_HIGH.

module tiled_texture_pixel_decoder_unit #(
   parameter int unsigned MAX_TILES_WIDE = 128,
   parameter int unsigned MAX_TILES_HIGH = 128
) (
   input  logic         clock,
   input  logic         reset,
   ttpd_req_if.sink     req_bus,
   ttpd_rsp_if.source   rsp_bus,
   ttpd_csr_if.sink     csr_bus
);

   localparam int unsigned COL_W = (MAX_TILES_WIDE > 1) ? $clog2(MAX_TILES_WIDE) : 1;
   localparam int unsigned ROW_W = (MAX_TILES_HIGH > 1) ? $clog2(MAX_TILES_HIGH) : 1;
   localparam int unsigned WT_W  = $clog2(MAX_TILES_WIDE + 1);
   localparam int unsigned HT_W  = $clog2(MAX_TILES_HIGH + 1);
   localparam int unsigned WCMP_W = (WT_W > ttpd_pkg::BYTE_W) ? WT_W : ttpd_pkg::BYTE_W;
   localparam int unsigned HCMP_W = (HT_W > ttpd_pkg::BYTE_W) ? HT_W : ttpd_pkg::BYTE_W;

   ttpd_pkg::fmt_type    fmt_ff, fmt_in;
   logic [WT_W-1:0]      wt_ff, wt_in;
   logic [HT_W-1:0]      ht_ff, ht_in;
   logic [WT_W-1:0]      wt_clamp;
   logic [HT_W-1:0]      ht_clamp;
   logic                 csr_write;
   logic                 clear;

   logic                 tex_valid;
   logic                 tex_ready;
   ttpd_pkg::texel_type  texel;
   logic [ROW_W+2:0]     row;
   logic [COL_W+2:0]     col;
   ttpd_pkg::pair_type   pair;

   // Register port always ready
   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   // Dimension clamping at write time
   always_comb begin
      if (csr_bus.data == '0) begin
         wt_clamp = WT_W'(1);
      end else if (WCMP_W'(csr_bus.data) > WCMP_W'(MAX_TILES_WIDE)) begin
         wt_clamp = WT_W'(MAX_TILES_WIDE);
      end else begin
         wt_clamp = WT_W'(csr_bus.data);
      end
      if (csr_bus.data == '0) begin
         ht_clamp = HT_W'(1);
      end else if (HCMP_W'(csr_bus.data) > HCMP_W'(MAX_TILES_HIGH)) begin
         ht_clamp = HT_W'(MAX_TILES_HIGH);
      end else begin
         ht_clamp = HT_W'(csr_bus.data);
      end
   end

   // Register writes; an unknown index changes nothing
   always_comb begin
      fmt_in = fmt_ff;
      wt_in  = wt_ff;
      ht_in  = ht_ff;
      clear  = 1'b0;
      if (csr_write) begin
         unique case (csr_bus.index)
            ttpd_pkg::CSR_PIXEL_FORMAT: begin
               fmt_in = ttpd_pkg::fmt_type'(csr_bus.data[2:0]);
               clear  = 1'b1;
            end
            ttpd_pkg::CSR_WIDTH_TILES: begin
               wt_in = wt_clamp;
               clear = 1'b1;
            end
            ttpd_pkg::CSR_HEIGHT_TILES: begin
               ht_in = ht_clamp;
               clear = 1'b1;
            end
            default: begin
               clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= ttpd_pkg::FMT_RGBA8888;
         wt_ff  <= WT_W'(1);
         ht_ff  <= HT_W'(1);
      end else begin
         fmt_ff <= fmt_in;
         wt_ff  <= wt_in;
         ht_ff  <= ht_in;
      end
   end

   // Byte gathering and tile walk
   ttpd_gather #(
      .COL_W (COL_W),
      .ROW_W (ROW_W),
      .WT_W  (WT_W),
      .HT_W  (HT_W)
   ) u_gather (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .fmt       (fmt_ff),
      .wt        (wt_ff),
      .ht        (ht_ff),
      .req       (req_bus),
      .tex_valid (tex_valid),
      .tex_ready (tex_ready),
      .texel     (texel),
      .row       (row),
      .col       (col)
   );

   // Expansion and index
   ttpd_expand #(
      .ROW_BITS (ROW_W + 3),
      .COL_BITS (COL_W + 3),
      .WT_BITS  (WT_W)
   ) u_expand (
      .fmt   (fmt_ff),
      .texel (texel),
      .row   (row),
      .col   (col),
      .wt    (wt_ff),
      .pair  (pair)
   );

   // Result register
   ttpd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .pair       (pair),
      .pair_valid (tex_valid),
      .pair_ready (tex_ready),
      .rsp        (rsp_bus)
   );

   // The last pixel of an image always closes its byte's run
   a_image_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.image_end |-> rsp_bus.run_end)
      else $error("image_end without run_end");

   // The first A4 pixel of a byte is immediately followed by its partner
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.run_end |=> rsp_bus.valid)
      else $error("second pixel of a byte missing");

   // An open run starts on an even column
   a_run_even_index: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.run_end |-> !rsp_bus.pixel_index[0])
      else $error("open run on odd pixel index");

   // A result only waits after a texel was produced
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(tex_valid))
      else $error("result without texel");

endmodule

[sim/tiled_texture_pixel_decoder_unit_tb.sv]
// Self-checking testbench for tiled_texture_pixel_decoder_unit: feeds texture bytes in all
// eight texel formats and compares every pixel with an in-bench decoder model.
// Depends on ttpd_pkg, ttpd_if and the decoder RTL.

module tiled_texture_pixel_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_TILES_WIDE = 128;
   localparam int unsigned MAX_TILES_HIGH = 128;
   localparam logic [1:0]  CSR_NO_REGISTER = 2'd3;
   localparam int          DRAIN_CYCLES = 6;
   localparam int          LONG_STALL_CYCLES = 250;
   localparam int          RANDOM_BYTES = 1100;

   logic clock;
   logic reset;

   ttpd_req_if req_bus ();
   ttpd_rsp_if rsp_bus ();
   ttpd_csr_if csr_bus ();

   tiled_texture_pixel_decoder_unit #(
      .MAX_TILES_WIDE(MAX_TILES_WIDE),
      .MAX_TILES_HIGH(MAX_TILES_HIGH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // Clock
   always #4 clock = ~clock;

   // Decoder model: register copies and walk state
   ttpd_pkg::fmt_type cfg_format = ttpd_pkg::FMT_RGBA8888;
   logic [7:0]  cfg_width = 8'd1;
   logic [7:0]  cfg_height = 8'd1;
   int          gather_phase = 0;
   logic [23:0] gather_bytes = '0;
   int          walk_texel = 0;
   int          walk_col = 0;
   int          walk_row = 0;

   // Stimulus and scoreboard bookkeeping
   logic [7:0]          byte_queue[$];
   ttpd_pkg::pixel_type pending_pixels[$];
   int         bytes_queued = 0;
   int         bytes_accepted = 0;
   int         pixels_checked = 0;
   int         images_seen = 0;
   int         reg_writes = 0;
   int         error_count = 0;
   logic       sender_calm = 1'b1;
   logic       receiver_calm = 1'b1;
   int         send_gap = 0;
   int         recv_gap = 0;
   int         long_stall_requests = 0;
   int         long_stall_served = 0;
   int         long_stall_left = 0;

   function automatic int texel_bytes(input ttpd_pkg::fmt_type f);
      case (f)
         ttpd_pkg::FMT_RGBA8888: return 4;
         ttpd_pkg::FMT_RGB888:   return 3;
         ttpd_pkg::FMT_RGBA5551,
         ttpd_pkg::FMT_RGB565,
         ttpd_pkg::FMT_LA88:     return 2;
         default:                return 1;
      endcase
   endfunction

   function automatic int clamp_tiles(input int v, input int maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] v);
      int t;
      t = v;
      return 8'((t << 3) | (t >> 2));
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      int t;
      t = v;
      return 8'((t << 2) | (t >> 4));
   endfunction

   // Morton position inside the current tile, then row-major pixel number
   function automatic logic [19:0] texel_index(input int t, input int wt);
      int x, y;
      x = (t & 1) | ((t >> 1) & 2) | ((t >> 2) & 4);
      y = ((t >> 1) & 1) | ((t >> 2) & 2) | ((t >> 3) & 4);
      return 20'((walk_row * 8 + y) * (wt * 8) + walk_col * 8 + x);
   endfunction

   function automatic void clear_walk();
      gather_phase = 0;
      gather_bytes = '0;
      walk_texel = 0;
      walk_col = 0;
      walk_row = 0;
   endfunction

   function automatic void apply_reg(input logic [1:0] idx, input logic [7:0] value);
      case (idx)
         ttpd_pkg::CSR_PIXEL_FORMAT: cfg_format = ttpd_pkg::fmt_type'(value[2:0]);
         ttpd_pkg::CSR_WIDTH_TILES:  cfg_width = value;
         ttpd_pkg::CSR_HEIGHT_TILES: cfg_height = value;
         default:                    return;
      endcase
      clear_walk();
   endfunction

   // Model one accepted byte: hold it, or finish a texel and queue its pixels
   function automatic void decode_byte(input logic [7:0] cur);
      int                  wt, ht, stride;
      logic [23:0]         h;
      logic [15:0]         p16;
      logic                img_end;
      ttpd_pkg::pixel_type px, px2;
      wt = clamp_tiles(cfg_width, MAX_TILES_WIDE);
      ht = clamp_tiles(cfg_height, MAX_TILES_HIGH);
      h = gather_bytes;
      if (gather_phase + 1 < texel_bytes(cfg_format)) begin
         gather_bytes = {h[15:0], cur};
         gather_phase++;
         return;
      end
      gather_phase = 0;
      gather_bytes = '0;
      stride = (cfg_format == ttpd_pkg::FMT_A4) ? 2 : 1;
      img_end = (walk_texel + stride >= 64) && (walk_col + 1 >= wt) && (walk_row + 1 >= ht);
      p16 = {cur, h[7:0]};
      px.pixel_index = texel_index(walk_texel, wt);
      px.run_end = 1'b1;
      px.image_end = img_end;
      px.blue = 8'hFF;
      px.green = 8'hFF;
      px.red = 8'hFF;
      px.alpha = 8'hFF;
      case (cfg_format)
         ttpd_pkg::FMT_RGBA8888: begin
            px.blue = cur;
            px.green = h[7:0];
            px.red = h[15:8];
            px.alpha = h[23:16];
         end
         ttpd_pkg::FMT_RGB888: begin
            px.blue = cur;
            px.green = h[7:0];
            px.red = h[15:8];
         end
         ttpd_pkg::FMT_RGBA5551: begin
            px.blue = widen5(p16[15:11]);
            px.green = widen5(p16[10:6]);
            px.red = widen5(p16[5:1]);
            px.alpha = p16[0] ? 8'hFF : 8'h00;
         end
         ttpd_pkg::FMT_RGB565: begin
            px.blue = widen5(p16[15:11]);
            px.green = widen6(p16[10:5]);
            px.red = widen5(p16[4:0]);
         end
         ttpd_pkg::FMT_LA88: begin
            px.blue = h[7:0];
            px.green = h[7:0];
            px.red = h[7:0];
            px.alpha = cur;
         end
         ttpd_pkg::FMT_A8: px.alpha = cur;
         ttpd_pkg::FMT_LA44: begin
            px.blue = 8'(cur[3:0] * 8'h11);
            px.green = px.blue;
            px.red = px.blue;
            px.alpha = 8'(cur[7:4] * 8'h11);
         end
         default: begin
            // A4: low nibble to the even column, high nibble to its neighbor
            px.alpha = 8'(cur[3:0] * 8'h11);
            px.run_end = 1'b0;
            px.image_end = 1'b0;
            px2 = px;
            px2.pixel_index = texel_index((walk_texel + 1) & 63, wt);
            px2.alpha = 8'(cur[7:4] * 8'h11);
            px2.run_end = 1'b1;
            px2.image_end = img_end;
         end
      endcase
      pending_pixels.push_back(px);
      if (cfg_format == ttpd_pkg::FMT_A4) pending_pixels.push_back(px2);

      // Advance through the tile, then across and down the tile grid
      walk_texel += stride;
      if (walk_texel >= 64) begin
         walk_texel = 0;
         walk_col++;
         if (walk_col >= wt) begin
            walk_col = 0;
            walk_row++;
            if (walk_row >= ht) walk_row = 0;
         end
      end
   endfunction

   function automatic int draw_gap(input logic calm);
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic check_field(input string name, input logic [19:0] want,
                              input logic [19:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   task automatic check_pixel();
      ttpd_pkg::pixel_type want;
      if (pending_pixels.size() == 0) begin
         error_count++;
         $display("%0t ns: unexpected pixel, expected none, actual index %0h",
                  $time, rsp_bus.pixel_index);
         return;
      end
      want = pending_pixels.pop_front();
      check_field("pixel_index", want.pixel_index, rsp_bus.pixel_index);
      check_field("blue", want.blue, rsp_bus.blue);
      check_field("green", want.green, rsp_bus.green);
      check_field("red", want.red, rsp_bus.red);
      check_field("alpha", want.alpha, rsp_bus.alpha);
      check_field("run_end", want.run_end, rsp_bus.run_end);
      check_field("image_end", want.image_end, rsp_bus.image_end);
      pixels_checked++;
      if (rsp_bus.image_end) images_seen++;
   endtask

   // Byte driver: one item from the queue, then a drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.raw_byte);
            bytes_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               req_bus.valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (byte_queue.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.raw_byte <= byte_queue.pop_front();
               send_gap <= draw_gap(sender_calm);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Pixel monitor: checks each item, then drops ready for a drawn stall
   always @(posedge clock) begin
      int wait_next;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_pixel();
            wait_next = draw_gap(receiver_calm);
         end else begin
            wait_next = (recv_gap > 0) ? recv_gap - 1 : 0;
         end
         recv_gap <= wait_next;
         rsp_bus.ready <= (wait_next == 0) && (long_stall_left == 0);
      end
   end

   // Long receiver hold-off, started on request from the stimulus
   always @(posedge clock) begin
      if (long_stall_left > 0)
         long_stall_left <= long_stall_left - 1;
      else if (long_stall_served != long_stall_requests) begin
         long_stall_left <= LONG_STALL_CYCLES;
         long_stall_served <= long_stall_served + 1;
      end
   end

   task automatic send(input logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued++;
   endtask

   // Idle: every byte taken, every pixel seen, pipeline flushed
   task automatic wait_idle();
      while (bytes_accepted != bytes_queued || pending_pixels.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
      wait_idle();
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      apply_reg(idx, value);
      reg_writes++;
   endtask

   task automatic set_format(input ttpd_pkg::fmt_type f);
      logic [7:0] value;
      value = 8'($urandom);
      value[2:0] = f;
      write_reg(ttpd_pkg::CSR_PIXEL_FORMAT, value);
   endtask

   function automatic logic [7:0] pick_tiles();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'd128;
         2:       return 8'd255;
         3:       return 8'($urandom_range(4, 127));
         default: return 8'($urandom_range(1, 3));
      endcase
   endfunction

   // Stimulus
   initial begin
      int         phase_no, n_bytes, wt, ht, texels, roll, random_bytes;
      logic [7:0] b;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.raw_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero sizes act as one tile
      write_reg(ttpd_pkg::CSR_WIDTH_TILES, 8'd0);
      write_reg(ttpd_pkg::CSR_HEIGHT_TILES, 8'd0);
      set_format(ttpd_pkg::FMT_RGBA8888);
      send(8'hFF); send(8'h00); send(8'hFF); send(8'h00);
      // Write to an unused index keeps the half-built texel
      send(8'hAA); send(8'h55);
      write_reg(CSR_NO_REGISTER, 8'hFF);
      send(8'h33); send(8'hCC);
      // A real register write drops a partial texel
      send(8'h12); send(8'h34); send(8'h56);
      set_format(ttpd_pkg::FMT_RGB888);
      send(8'h00); send(8'hFF); send(8'h80);
      set_format(ttpd_pkg::FMT_RGBA5551);
      send(8'h01); send(8'h80); send(8'hFE); send(8'h7F);
      set_format(ttpd_pkg::FMT_RGB565);
      send(8'h00); send(8'hFF);
      // Oversized dimensions clamp; third texel lands one row down
      write_reg(ttpd_pkg::CSR_WIDTH_TILES, 8'd255);
      write_reg(ttpd_pkg::CSR_HEIGHT_TILES, 8'd255);
      set_format(ttpd_pkg::FMT_LA88);
      send(8'h7F); send(8'h80);
      set_format(ttpd_pkg::FMT_A8);
      send(8'h00); send(8'hFF); send(8'h01);
      set_format(ttpd_pkg::FMT_LA44);
      send(8'hF0); send(8'h0F);
      set_format(ttpd_pkg::FMT_A4);
      send(8'h0F); send(8'hF0);

      // Random phases: new settings, whole images where they are small
      phase_no = 0;
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         if (phase_no == 2) begin
            // Back-pressure: A4 doubles the output while the receiver holds off
            write_reg(ttpd_pkg::CSR_WIDTH_TILES, 8'd1);
            write_reg(ttpd_pkg::CSR_HEIGHT_TILES, 8'd1);
            set_format(ttpd_pkg::FMT_A4);
            sender_calm = 1'b1;
            receiver_calm = 1'b0;
            long_stall_requests++;
            n_bytes = 120;
         end else begin
            roll = $urandom_range(0, 7);
            if (roll != 0) set_format(ttpd_pkg::fmt_type'($urandom_range(0, 7)));
            if (roll < 3) write_reg(ttpd_pkg::CSR_WIDTH_TILES, pick_tiles());
            if (roll < 3 || roll == 6) write_reg(ttpd_pkg::CSR_HEIGHT_TILES, pick_tiles());
            if (roll == 7) write_reg(CSR_NO_REGISTER, 8'($urandom));
            sender_calm = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            wt = clamp_tiles(cfg_width, MAX_TILES_WIDE);
            ht = clamp_tiles(cfg_height, MAX_TILES_HIGH);
            texels = wt * ht * 64;
            n_bytes = (cfg_format == ttpd_pkg::FMT_A4) ? texels / 2
                                                       : texels * texel_bytes(cfg_format);
            if (n_bytes > 320 || $urandom_range(0, 2) == 0) n_bytes = $urandom_range(16, 150);
         end
         repeat (n_bytes) begin
            roll = $urandom_range(0, 7);
            b = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom);
            send(b);
         end
         random_bytes += n_bytes;
         phase_no++;
      end

      wait_idle();
      $display("Sent %0d bytes over %0d register writes; checked %0d pixels, %0d image ends.",
               bytes_accepted, reg_writes, pixels_checked, images_seen);
      if (error_count == 0)
         $display("** tiled_texture_pixel_decoder_unit: PASSED **");
      else
         $display("** tiled_texture_pixel_decoder_unit: FAILED **");
      $finish;
   end

   // Run limit
   initial begin
      #5000000;
      $display("Timeout: %0d pixels still expected", pending_pixels.size());
      $display("** tiled_texture_pixel_decoder_unit: FAILED **");
      $finish;
   end

endmodule
